// ===== hw/rtl/thrust_ramp_envelope_assert.svh =====
// assertion macros for the envelope rtl
`ifndef THRUST_RAMP_ENVELOPE_ASSERT_SVH
`define THRUST_RAMP_ENVELOPE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TRENV_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("envelope check failed");

// next-cycle implication, checked outside reset
`define TRENV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("envelope check failed");

`endif

// ===== hw/rtl/trenv_pkg.sv =====
package trenv_pkg;

	localparam int LEVEL_BITS_DEF = 16;
	localparam int CFG_W          = 16;
	localparam int CFG_IDX_W      = 3;
	localparam int PHASE_W        = 3;
	localparam int DRIVE_W        = 16;

	localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
	localparam logic [PHASE_W-1:0] PH_ATTACK  = 3'd1;
	localparam logic [PHASE_W-1:0] PH_DECAY   = 3'd2;
	localparam logic [PHASE_W-1:0] PH_SUSTAIN = 3'd3;
	localparam logic [PHASE_W-1:0] PH_RELEASE = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_ATTACK_STEP   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PEAK_LEVEL    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY_STEP    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN_LEVEL = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_STEP  = 3'd4;

	localparam logic [CFG_W-1:0] ATTACK_STEP_RST   = 16'd256;
	localparam logic [CFG_W-1:0] PEAK_LEVEL_RST    = 16'd49152;
	localparam logic [CFG_W-1:0] DECAY_STEP_RST    = 16'd128;
	localparam logic [CFG_W-1:0] SUSTAIN_LEVEL_RST = 16'd32768;
	localparam logic [CFG_W-1:0] RELEASE_STEP_RST  = 16'd256;

	typedef struct packed {
		logic [CFG_W-1:0] attack_step;
		logic [CFG_W-1:0] peak_level;
		logic [CFG_W-1:0] decay_step;
		logic [CFG_W-1:0] sustain_level;
		logic [CFG_W-1:0] release_step;
	} cfg_t;

endpackage

// ===== hw/rtl/trenv_cfg.sv =====
module trenv_cfg import trenv_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.attack_step   <= ATTACK_STEP_RST;
			cfg_q.peak_level    <= PEAK_LEVEL_RST;
			cfg_q.decay_step    <= DECAY_STEP_RST;
			cfg_q.sustain_level <= SUSTAIN_LEVEL_RST;
			cfg_q.release_step  <= RELEASE_STEP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ATTACK_STEP:   cfg_q.attack_step   <= cfg_data;
				REG_PEAK_LEVEL:    cfg_q.peak_level    <= cfg_data;
				REG_DECAY_STEP:    cfg_q.decay_step    <= cfg_data;
				REG_SUSTAIN_LEVEL: cfg_q.sustain_level <= cfg_data;
				REG_RELEASE_STEP:  cfg_q.release_step  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hw/rtl/trenv_update.sv =====
module trenv_update import trenv_pkg::*; #(
	parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
	input  cfg_t                  cfg,
	input  logic [PHASE_W-1:0]    phase_in,
	input  logic [LEVEL_BITS-1:0] level_in,
	input  logic                  press,
	input  logic                  release_ev,
	output logic [PHASE_W-1:0]    next_phase,
	output logic [LEVEL_BITS-1:0] next_level,
	output logic [DRIVE_W-1:0]    drive_level
);

	// one guard bit above the wider of level and register width
	localparam int SW = ((LEVEL_BITS > CFG_W) ? LEVEL_BITS : CFG_W) + 1;
	localparam logic [SW-1:0] MAX_W = {{(SW-LEVEL_BITS){1'b0}}, {LEVEL_BITS{1'b1}}};

	logic [SW-1:0]      lvl_w;
	logic [SW-1:0]      att_w;
	logic [SW-1:0]      dec_w;
	logic [SW-1:0]      rel_w;
	logic [SW-1:0]      peak_w;
	logic [SW-1:0]      sus_w;
	logic [SW-1:0]      peak_c;
	logic [SW-1:0]      sus_c;
	logic [SW-1:0]      att_sum;
	logic [SW-1:0]      att_clamp;
	logic [SW-1:0]      dec_diff;
	logic [SW-1:0]      rel_diff;
	logic [SW-1:0]      next_w;
	logic [PHASE_W-1:0] ph;

	assign lvl_w  = {{(SW-LEVEL_BITS){1'b0}}, level_in};
	assign att_w  = {{(SW-CFG_W){1'b0}}, cfg.attack_step};
	assign dec_w  = {{(SW-CFG_W){1'b0}}, cfg.decay_step};
	assign rel_w  = {{(SW-CFG_W){1'b0}}, cfg.release_step};
	assign peak_w = {{(SW-CFG_W){1'b0}}, cfg.peak_level};
	assign sus_w  = {{(SW-CFG_W){1'b0}}, cfg.sustain_level};

	// register values beyond the level range saturate
	assign peak_c = (peak_w > MAX_W) ? MAX_W : peak_w;
	assign sus_c  = (sus_w > MAX_W) ? MAX_W : sus_w;

	assign att_sum   = lvl_w + att_w;
	assign att_clamp = (att_sum > MAX_W) ? MAX_W : att_sum;
	assign dec_diff  = (lvl_w > dec_w) ? (lvl_w - dec_w) : '0;
	assign rel_diff  = (lvl_w > rel_w) ? (lvl_w - rel_w) : '0;

	// release wins over press
	always_comb begin
		ph = phase_in;
		if (press)
			ph = PH_ATTACK;
		if (release_ev)
			ph = PH_RELEASE;
	end

	always_comb begin
		next_phase = ph;
		next_w     = '0;
		case (ph)
			PH_ATTACK: begin
				if (att_clamp >= peak_c) begin
					next_w     = peak_c;
					next_phase = PH_DECAY;
				end else begin
					next_w = att_clamp;
				end
			end
			PH_DECAY: begin
				if (dec_diff <= sus_c) begin
					next_w     = sus_c;
					next_phase = PH_SUSTAIN;
				end else begin
					next_w = dec_diff;
				end
			end
			PH_SUSTAIN: begin
				next_w = sus_c;
			end
			PH_RELEASE: begin
				next_w = rel_diff;
				if (rel_diff == '0)
					next_phase = PH_IDLE;
			end
			default: begin
				next_w     = '0;
				next_phase = PH_IDLE;
			end
		endcase
	end

	assign next_level  = next_w[LEVEL_BITS-1:0];
	assign drive_level = next_w[DRIVE_W-1:0];

endmodule

// ===== hw/rtl/thrust_ramp_envelope.sv =====
// Linear attack-decay-sustain-release drive envelope, one tick per item.
// Input channel in_valid/in_ready carries press_event and release_event;
// release wins when both are set, press restarts attack from the current level.
// Output channel out_valid/out_ready returns one item per tick: drive_level,
// phase (0 idle, 1 attack, 2 decay, 3 sustain, 4 release) and active.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data) for the
// five step/level registers; write it only while no tick is in flight.
// A tick passes from the input register through the update logic into the
// output register, where it is shown.
// Throughput: one tick per cycle while out_ready stays high; the add, compare
// and phase select between the input and output registers set the pace.
// A stalled receiver holds the output register; the input register still takes
// one more tick, then in_ready drops until the output moves on.
// Reset clears the envelope to idle at level zero, empties both registers and
// loads the register defaults.
`include "thrust_ramp_envelope_assert.svh"

module thrust_ramp_envelope import trenv_pkg::*; #(
	parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 press_event,
	input  logic                 release_event,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [DRIVE_W-1:0]   drive_level,
	output logic [PHASE_W-1:0]   phase,
	output logic                 active
);

	cfg_t                  cfg;
	logic                  valid_s1;
	logic                  press_s1;
	logic                  release_s1;
	logic                  valid_s2;
	logic [DRIVE_W-1:0]    drive_level_s2;
	logic [PHASE_W-1:0]    phase_s2;
	logic                  active_s2;
	logic [PHASE_W-1:0]    phase_q;
	logic [LEVEL_BITS-1:0] level_q;
	logic [PHASE_W-1:0]    next_phase;
	logic [LEVEL_BITS-1:0] next_level;
	logic [DRIVE_W-1:0]    next_drive;
	logic                  advance;

	trenv_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	trenv_update #(
		.LEVEL_BITS (LEVEL_BITS)
	) u_update (
		.cfg         (cfg),
		.phase_in    (phase_q),
		.level_in    (level_q),
		.press       (press_s1),
		.release_ev  (release_s1),
		.next_phase  (next_phase),
		.next_level  (next_level),
		.drive_level (next_drive)
	);

	// the item in stage 1 moves on when the output register is free or draining
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			press_s1   <= press_event;
			release_s1 <= release_event;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			level_q <= '0;
		end else if (advance) begin
			phase_q <= next_phase;
			level_q <= next_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			drive_level_s2 <= next_drive;
			phase_s2       <= next_phase;
			active_s2      <= (next_phase != PH_IDLE);
		end
	end

	assign out_valid   = valid_s2;
	assign drive_level = drive_level_s2;
	assign phase       = phase_s2;
	assign active      = active_s2;

	`TRENV_ASSERT_NOW(a_idle_level_zero, clk, arst_n, phase_q == PH_IDLE, level_q == '0)
	`TRENV_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, in_valid && in_ready, valid_s1)
	`TRENV_ASSERT_NEXT(a_state_holds, clk, arst_n, !advance, $stable(phase_q) && $stable(level_q))

endmodule

// ===== dv/thrust_ramp_envelope_tb.sv =====
module thrust_ramp_envelope_tb import trenv_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [DRIVE_W-1:0] level;
		logic [PHASE_W-1:0] ph;
		logic               act;
	} env_out_t;

	typedef enum logic [1:0] {ROW_TICK, ROW_KNOWN, ROW_REG} row_kind_t;

	typedef struct packed {
		row_kind_t            kind;
		logic                 press;
		logic                 rel;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_W-1:0]     data;
		env_out_t             due;
	} stim_row_t;

	localparam int RAND_PHASES = 8;
	localparam int PHASE_TICKS = 150;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic press_event;
	logic release_event;
	logic out_valid;
	logic out_ready;
	logic [DRIVE_W-1:0] drive_level;
	logic [PHASE_W-1:0] phase;
	logic active;

	// shadow of the block: registers, phase and level
	cfg_t env_cfg;
	logic [PHASE_W-1:0] env_phase;
	logic [DRIVE_W-1:0] env_level;

	env_out_t envelope_due_q[$];
	stim_row_t dir_tbl[$];
	int errors = 0;
	int burst_left = 0;
	int ticks_sent;
	bit cfg_open;

	always #2 clk = ~clk;

	thrust_ramp_envelope u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.press_event(press_event),
		.release_event(release_event),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.drive_level(drive_level),
		.phase(phase),
		.active(active)
	);

	function automatic env_out_t advance_envelope(input logic p, input logic r);
		env_out_t o;
		logic [DRIVE_W:0] sum;
		logic [DRIVE_W-1:0] nxt;
		if (p) env_phase = PH_ATTACK;
		if (r) env_phase = PH_RELEASE;
		case (env_phase)
			PH_ATTACK: begin
				sum = {1'b0, env_level} + {1'b0, env_cfg.attack_step};
				nxt = sum[DRIVE_W] ? {DRIVE_W{1'b1}} : sum[DRIVE_W-1:0];
				if (nxt >= env_cfg.peak_level) begin
					nxt = env_cfg.peak_level;
					env_phase = PH_DECAY;
				end
			end
			PH_DECAY: begin
				nxt = (env_level > env_cfg.decay_step) ? env_level - env_cfg.decay_step : '0;
				if (nxt <= env_cfg.sustain_level) begin
					nxt = env_cfg.sustain_level;
					env_phase = PH_SUSTAIN;
				end
			end
			PH_SUSTAIN: nxt = env_cfg.sustain_level;
			PH_RELEASE: begin
				nxt = (env_level > env_cfg.release_step) ? env_level - env_cfg.release_step : '0;
				if (nxt == '0) env_phase = PH_IDLE;
			end
			default: begin
				env_phase = PH_IDLE;
				nxt = '0;
			end
		endcase
		env_level = nxt;
		o.level = nxt;
		o.ph = env_phase;
		o.act = (env_phase != PH_IDLE);
		return o;
	endfunction

	function automatic stim_row_t tick_row(input logic p, input logic r);
		stim_row_t s;
		s = '0;
		s.kind = ROW_TICK;
		s.press = p;
		s.rel = r;
		return s;
	endfunction

	function automatic stim_row_t known_row(input logic p, input logic r,
		input logic [DRIVE_W-1:0] lvl, input logic [PHASE_W-1:0] ph, input logic act);
		stim_row_t s;
		s = tick_row(p, r);
		s.kind = ROW_KNOWN;
		s.due = '{level: lvl, ph: ph, act: act};
		return s;
	endfunction

	function automatic stim_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_W-1:0] data);
		stim_row_t s;
		s = '0;
		s.kind = ROW_REG;
		s.idx = idx;
		s.data = data;
		return s;
	endfunction

	function automatic logic [CFG_W-1:0] pick_step();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3: return CFG_W'($urandom_range(1, 16));
			4, 5, 6, 7: return CFG_W'($urandom_range(16, 4096));
			default: return CFG_W'($urandom);
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] pick_level();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return CFG_W'($urandom);
		endcase
	endfunction

	// one item; known rows use the typed result, all others the shadow model
	task automatic send_tick(input logic p, input logic r, input logic known,
		input env_out_t typed);
		env_out_t pred;
		@(negedge clk);
		in_valid <= 1'b1;
		press_event <= p;
		release_event <= r;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pred = advance_envelope(p, r);
		envelope_due_q.push_back(known ? typed : pred);
	endtask

	task automatic pace_tick(input logic p, input logic r);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if ($urandom_range(0, 2) != 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (($urandom_range(0, 7) == 0) ? 20 : $urandom_range(0, 5))
					@(negedge clk);
			end
		end
		burst_left--;
		send_tick(p, r, 1'b0, '0);
		ticks_sent++;
	endtask

	// block must be empty before any register write
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (envelope_due_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_ATTACK_STEP:   env_cfg.attack_step = data;
			REG_PEAK_LEVEL:    env_cfg.peak_level = data;
			REG_DECAY_STEP:    env_cfg.decay_step = data;
			REG_SUSTAIN_LEVEL: env_cfg.sustain_level = data;
			REG_RELEASE_STEP:  env_cfg.release_step = data;
			default: ;
		endcase
	endtask

	task automatic end_writes();
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// receiver: stretches of full rate, light stalls, heavy stalls and a fixed rhythm
	initial begin
		int mode;
		int len;
		int n;
		out_ready = 1'b0;
		n = 0;
		forever begin
			mode = $urandom_range(0, 3);
			len = $urandom_range(20, 200);
			repeat (len) begin
				@(negedge clk);
				n++;
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 3) != 0);
					2: out_ready <= ($urandom_range(0, 3) == 0);
					default: out_ready <= ((n % 5) < 2);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		env_out_t exp_out;
		if (arst_n && out_valid && out_ready) begin
			if (envelope_due_q.size() == 0) begin
				$display("%0t: unexpected item level %0d phase %0d active %0d",
					$time, drive_level, phase, active);
				errors++;
			end else begin
				exp_out = envelope_due_q.pop_front();
				if (drive_level !== exp_out.level) begin
					$display("%0t: drive_level expected %0d actual %0d",
						$time, exp_out.level, drive_level);
					errors++;
				end
				if (phase !== exp_out.ph) begin
					$display("%0t: phase expected %0d actual %0d", $time, exp_out.ph, phase);
					errors++;
				end
				if (active !== exp_out.act) begin
					$display("%0t: active expected %0d actual %0d", $time, exp_out.act, active);
					errors++;
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		press_event = 1'b0;
		release_event = 1'b0;
		env_cfg = '{attack_step: ATTACK_STEP_RST, peak_level: PEAK_LEVEL_RST,
			decay_step: DECAY_STEP_RST, sustain_level: SUSTAIN_LEVEL_RST,
			release_step: RELEASE_STEP_RST};
		env_phase = PH_IDLE;
		env_level = '0;

		dir_tbl = '{
			// release while idle, then a plain idle tick
			known_row(1'b0, 1'b1, 16'd0, PH_IDLE, 1'b0),
			known_row(1'b0, 1'b0, 16'd0, PH_IDLE, 1'b0),
			known_row(1'b1, 1'b0, 16'd256, PH_ATTACK, 1'b1),
			// both flags: release wins
			known_row(1'b1, 1'b1, 16'd0, PH_IDLE, 1'b0),
			reg_row(REG_ATTACK_STEP, 16'hffff),
			reg_row(REG_DECAY_STEP, 16'hffff),
			reg_row(REG_RELEASE_STEP, 16'd0),
			// attack sum saturates, decay difference floors at zero
			known_row(1'b1, 1'b0, 16'd49152, PH_DECAY, 1'b1),
			known_row(1'b0, 1'b0, 16'd32768, PH_SUSTAIN, 1'b1),
			known_row(1'b0, 1'b0, 16'd32768, PH_SUSTAIN, 1'b1),
			known_row(1'b1, 1'b0, 16'd49152, PH_DECAY, 1'b1),
			// zero release step holds the level
			known_row(1'b0, 1'b1, 16'd49152, PH_RELEASE, 1'b1),
			known_row(1'b0, 1'b0, 16'd49152, PH_RELEASE, 1'b1),
			reg_row(REG_PEAK_LEVEL, 16'hffff),
			reg_row(REG_SUSTAIN_LEVEL, 16'hffff),
			reg_row(REG_RELEASE_STEP, 16'hffff),
			reg_row(REG_ATTACK_STEP, 16'd0),
			known_row(1'b0, 1'b0, 16'd0, PH_IDLE, 1'b0),
			// zero attack step never reaches the peak
			known_row(1'b1, 1'b0, 16'd0, PH_ATTACK, 1'b1),
			reg_row(REG_ATTACK_STEP, 16'hffff),
			known_row(1'b0, 1'b0, 16'hffff, PH_DECAY, 1'b1),
			known_row(1'b0, 1'b0, 16'hffff, PH_SUSTAIN, 1'b1),
			reg_row(REG_PEAK_LEVEL, 16'd0),
			reg_row(REG_SUSTAIN_LEVEL, 16'd0),
			reg_row(REG_ATTACK_STEP, 16'd1),
			reg_row(REG_DECAY_STEP, 16'd0),
			known_row(1'b1, 1'b0, 16'd0, PH_DECAY, 1'b1),
			known_row(1'b0, 1'b0, 16'd0, PH_SUSTAIN, 1'b1),
			known_row(1'b0, 1'b1, 16'd0, PH_IDLE, 1'b0),
			tick_row(1'b1, 1'b0),
			// sustain above peak
			reg_row(REG_PEAK_LEVEL, 16'd1000),
			reg_row(REG_SUSTAIN_LEVEL, 16'd5000),
			reg_row(REG_ATTACK_STEP, 16'd300),
			reg_row(REG_DECAY_STEP, 16'd1),
			tick_row(1'b1, 1'b0),
			tick_row(1'b0, 1'b0),
			tick_row(1'b0, 1'b0),
			tick_row(1'b0, 1'b0),
			tick_row(1'b0, 1'b0),
			known_row(1'b0, 1'b1, 16'd0, PH_IDLE, 1'b0)
		};

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		cfg_open = 1'b0;
		foreach (dir_tbl[i]) begin
			if (dir_tbl[i].kind == ROW_REG) begin
				if (!cfg_open) settle();
				cfg_open = 1'b1;
				write_reg(dir_tbl[i].idx, dir_tbl[i].data);
			end else begin
				if (cfg_open) end_writes();
				cfg_open = 1'b0;
				send_tick(dir_tbl[i].press, dir_tbl[i].rel,
					dir_tbl[i].kind == ROW_KNOWN, dir_tbl[i].due);
			end
		end

		for (int ph_i = 0; ph_i < RAND_PHASES; ph_i++) begin
			settle();
			write_reg(REG_ATTACK_STEP, pick_step());
			write_reg(REG_PEAK_LEVEL, pick_level());
			write_reg(REG_DECAY_STEP, pick_step());
			write_reg(REG_SUSTAIN_LEVEL, pick_level());
			write_reg(REG_RELEASE_STEP, pick_step());
			end_writes();
			ticks_sent = 0;
			while (ticks_sent < PHASE_TICKS) begin
				if ($urandom_range(0, 4) == 0) begin
					pace_tick(1'($urandom_range(0, 1)), $urandom_range(0, 2) == 0);
				end else begin
					// press, hold, release, let it ring out
					pace_tick(1'b1, 1'b0);
					repeat (($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
						: $urandom_range(0, 40))
						pace_tick(1'b0, 1'b0);
					pace_tick($urandom_range(0, 5) == 0, 1'b1);
					repeat ($urandom_range(0, 40)) pace_tick(1'b0, 1'b0);
				end
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (envelope_due_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/trenv_pkg.sv
hw/rtl/trenv_cfg.sv
hw/rtl/trenv_update.sv
hw/rtl/thrust_ramp_envelope.sv
dv/thrust_ramp_envelope_tb.sv
